// ===== hw/rtl/ldr_pkg.sv =====
// Shared types, constants and the glyph font for the LED matrix delta refresh block.
// Used by every module under hw/rtl; depends on nothing else.
package ldr_pkg;

    // Frame geometry and colour depth
    localparam int ROWS       = 7;
    localparam int COLS       = 7;
    localparam int COLOR_BITS = 8;
    localparam int GLYPH_SIZE = 7;
    localparam int NUM_DIGITS = 10;
    localparam int NPIX       = ROWS * COLS;
    localparam int IDX_W      = $clog2(NPIX);

    // Fixed field widths of the command and LED write items
    localparam int KIND_W  = 2;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int DIGIT_W = 4;

    // Command kinds as they arrive on the input channel
    localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIGIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd2;

    // Depth of the command queue between the front and the back
    localparam int FIFO_DEPTH = 2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pixel_t;

    // Operation carried out by the back end
    typedef enum logic [1:0] {
        OP_MOVE,
        OP_DIGIT,
        OP_REFRESH
    } op_t;

    // One classified command in the queue
    typedef struct packed {
        op_t                op;
        logic               clr_ok;
        logic               paint_ok;
        idx_t               clr_idx;
        idx_t               paint_idx;
        logic [DIGIT_W-1:0] digit;
        pixel_t             fg;
        pixel_t             bg;
    } cmd_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PAINT,
        ST_FILL,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Glyph font: bit c of row r is column c of the digit
    localparam logic [GLYPH_SIZE-1:0] FONT [NUM_DIGITS][GLYPH_SIZE] = '{
        '{7'h1C, 7'h22, 7'h22, 7'h22, 7'h22, 7'h22, 7'h1C},
        '{7'h10, 7'h18, 7'h14, 7'h12, 7'h10, 7'h10, 7'h10},
        '{7'h1C, 7'h22, 7'h20, 7'h1C, 7'h02, 7'h02, 7'h04},
        '{7'h1C, 7'h22, 7'h20, 7'h1C, 7'h20, 7'h22, 7'h1C},
        '{7'h10, 7'h18, 7'h14, 7'h3E, 7'h10, 7'h10, 7'h10},
        '{7'h3E, 7'h02, 7'h02, 7'h1E, 7'h20, 7'h20, 7'h1E},
        '{7'h1C, 7'h22, 7'h02, 7'h1E, 7'h22, 7'h22, 7'h1C},
        '{7'h3E, 7'h20, 7'h20, 7'h38, 7'h20, 7'h20, 7'h20},
        '{7'h1C, 7'h22, 7'h22, 7'h1C, 7'h22, 7'h22, 7'h1C},
        '{7'h1C, 7'h22, 7'h22, 7'h3C, 7'h20, 7'h22, 7'h1C}
    };

endpackage

// ===== hw/rtl/ldr_front.sv =====
// Front end: accepts command items, classifies them and pushes them into the queue.
// Depends on ldr_pkg.
module ldr_front (
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [ldr_pkg::KIND_W-1:0]      kind,
    input  logic [ldr_pkg::ROW_W-1:0]       from_row,
    input  logic [ldr_pkg::COL_W-1:0]       from_col,
    input  logic [ldr_pkg::ROW_W-1:0]       to_row,
    input  logic [ldr_pkg::COL_W-1:0]       to_col,
    input  logic [ldr_pkg::DIGIT_W-1:0]     digit,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_red,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_green,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_blue,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_red,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_green,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_blue,
    input  logic                            q_full,
    output logic                            q_push,
    output ldr_pkg::cmd_t                   q_cmd
);

    logic keep;

    // The queue being full is the only reason to hold off the sender
    assign cmd_stall = q_full;

    // Classify the item; unused kinds and digits above nine cause no work at all
    always_comb
    begin
        q_cmd           = '0;
        keep            = 1'b0;
        q_cmd.clr_ok    = (int'(from_row) < ldr_pkg::ROWS) && (int'(from_col) < ldr_pkg::COLS);
        q_cmd.paint_ok  = (int'(to_row) < ldr_pkg::ROWS) && (int'(to_col) < ldr_pkg::COLS);
        q_cmd.clr_idx   = ldr_pkg::IDX_W'(int'(from_row) * ldr_pkg::COLS + int'(from_col));
        q_cmd.paint_idx = ldr_pkg::IDX_W'(int'(to_row) * ldr_pkg::COLS + int'(to_col));
        q_cmd.digit     = digit;
        q_cmd.fg        = '{red: fg_red, green: fg_green, blue: fg_blue};
        q_cmd.bg        = '{red: bg_red, green: bg_green, blue: bg_blue};
        q_cmd.op        = ldr_pkg::OP_REFRESH;
        case (kind)
            ldr_pkg::KIND_MOVE:
            begin
                q_cmd.op = ldr_pkg::OP_MOVE;
                keep     = 1'b1;
            end
            ldr_pkg::KIND_DIGIT:
            begin
                q_cmd.op = ldr_pkg::OP_DIGIT;
                keep     = (int'(digit) < ldr_pkg::NUM_DIGITS);
            end
            ldr_pkg::KIND_REFRESH:
            begin
                q_cmd.op = ldr_pkg::OP_REFRESH;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = cmd_valid && !q_full && keep;

endmodule

// ===== hw/rtl/ldr_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on ldr_pkg for the command type and the queue depth.
module ldr_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ldr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ldr_pkg::cmd_t  head
);

    localparam int PTR_W = (ldr_pkg::FIFO_DEPTH > 1) ? $clog2(ldr_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(ldr_pkg::FIFO_DEPTH + 1);

    ldr_pkg::cmd_t    entry_reg [ldr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(ldr_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ldr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ldr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ldr_back.sv =====
// Back end: carries out queued commands on the target frame and scans for LED writes.
// Depends on ldr_pkg; holds the target frame and shadow frame memories.
module ldr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  ldr_pkg::cmd_t                   q_head,
    output logic                            q_pop,
    output logic                            led_valid,
    input  logic                            led_stall,
    output logic [ldr_pkg::ROW_W-1:0]       led_row,
    output logic [ldr_pkg::COL_W-1:0]       led_col,
    output logic [ldr_pkg::COLOR_BITS-1:0]  red,
    output logic [ldr_pkg::COLOR_BITS-1:0]  green,
    output logic [ldr_pkg::COLOR_BITS-1:0]  blue,
    output logic                            last
);

    ldr_pkg::state_t state_reg;
    ldr_pkg::state_t state_next;
    ldr_pkg::cmd_t   cur_reg;

    // Frame memories and valid bits of the target frame
    ldr_pkg::pixel_t          tmem [ldr_pkg::NPIX];
    ldr_pkg::pixel_t          smem [ldr_pkg::NPIX];
    logic [ldr_pkg::NPIX-1:0] tvalid_reg;
    logic                     primed_reg;

    // Scan counters
    ldr_pkg::idx_t             idx_reg;
    logic [ldr_pkg::ROW_W-1:0] row_reg;
    logic [ldr_pkg::COL_W-1:0] col_reg;

    // Compare stage
    logic                      b_vld_reg;
    ldr_pkg::idx_t             b_idx_reg;
    logic [ldr_pkg::ROW_W-1:0] b_row_reg;
    logic [ldr_pkg::COL_W-1:0] b_col_reg;
    ldr_pkg::pixel_t           t_rd_reg;
    ldr_pkg::pixel_t           s_rd_reg;
    logic                      tv_rd_reg;

    // Pending write, held until it is known whether it is the last one
    logic                      pend_vld_reg;
    logic [ldr_pkg::ROW_W-1:0] pend_row_reg;
    logic [ldr_pkg::COL_W-1:0] pend_col_reg;
    ldr_pkg::pixel_t           pend_pix_reg;

    // Output register
    logic                      out_vld_reg;
    logic [ldr_pkg::ROW_W-1:0] out_row_reg;
    logic [ldr_pkg::COL_W-1:0] out_col_reg;
    ldr_pkg::pixel_t           out_pix_reg;
    logic                      out_last_reg;

    // Control decodes
    logic            last_pix;
    logic            out_free;
    ldr_pkg::pixel_t t_eff;
    logic            b_diff;
    logic            take_b;
    logic            adv;
    logic            mid_push;
    logic            flush;
    logic            scan_step;
    logic            t_we;
    ldr_pkg::idx_t   t_addr;
    ldr_pkg::pixel_t t_wdata;
    logic            glyph_bit;
    logic            in_glyph;

    assign last_pix = (idx_reg == ldr_pkg::IDX_W'(ldr_pkg::NPIX - 1));
    assign out_free = !out_vld_reg || !led_stall;
    assign t_eff    = tv_rd_reg ? t_rd_reg : '0;
    assign b_diff   = !primed_reg || (t_eff != s_rd_reg);
    assign take_b   = b_vld_reg && b_diff;
    assign adv      = !(take_b && pend_vld_reg && !out_free);
    assign mid_push = adv && take_b && pend_vld_reg;
    assign in_glyph = (int'(row_reg) < ldr_pkg::GLYPH_SIZE) &&
                      (int'(col_reg) < ldr_pkg::GLYPH_SIZE);
    assign glyph_bit = ldr_pkg::FONT[cur_reg.digit][row_reg][col_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ldr_pkg::ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    case (q_head.op)
                        ldr_pkg::OP_MOVE:    state_next = ldr_pkg::ST_CLEAR;
                        ldr_pkg::OP_DIGIT:   state_next = ldr_pkg::ST_FILL;
                        ldr_pkg::OP_REFRESH: state_next = ldr_pkg::ST_SCAN;
                        default:             state_next = ldr_pkg::ST_IDLE;
                    endcase
                end
            end
            ldr_pkg::ST_CLEAR:
            begin
                state_next = ldr_pkg::ST_PAINT;
            end
            ldr_pkg::ST_PAINT:
            begin
                state_next = ldr_pkg::ST_SCAN;
            end
            ldr_pkg::ST_FILL:
            begin
                if (last_pix)
                begin
                    state_next = ldr_pkg::ST_IDLE;
                end
            end
            ldr_pkg::ST_SCAN:
            begin
                if (adv && last_pix)
                begin
                    state_next = ldr_pkg::ST_DRAIN;
                end
            end
            ldr_pkg::ST_DRAIN:
            begin
                if (!b_vld_reg && (!pend_vld_reg || out_free))
                begin
                    state_next = ldr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ldr_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, target writes, counter stepping and final flush
    always_comb
    begin
        q_pop     = 1'b0;
        t_we      = 1'b0;
        t_addr    = idx_reg;
        t_wdata   = '0;
        scan_step = 1'b0;
        flush     = 1'b0;
        case (state_reg)
            ldr_pkg::ST_IDLE:
            begin
                q_pop = q_not_empty;
            end
            ldr_pkg::ST_CLEAR:
            begin
                t_we   = cur_reg.clr_ok;
                t_addr = cur_reg.clr_idx;
            end
            ldr_pkg::ST_PAINT:
            begin
                t_we    = cur_reg.paint_ok;
                t_addr  = cur_reg.paint_idx;
                t_wdata = cur_reg.fg;
            end
            ldr_pkg::ST_FILL:
            begin
                t_we      = in_glyph;
                t_wdata   = glyph_bit ? cur_reg.fg : cur_reg.bg;
                scan_step = 1'b1;
            end
            ldr_pkg::ST_SCAN:
            begin
                scan_step = adv;
            end
            ldr_pkg::ST_DRAIN:
            begin
                flush = !b_vld_reg && pend_vld_reg && out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ldr_pkg::ST_IDLE;
            tvalid_reg   <= '0;
            primed_reg   <= 1'b0;
            idx_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            b_vld_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (t_we)
            begin
                tvalid_reg[t_addr] <= 1'b1;
            end
            if (state_reg == ldr_pkg::ST_DRAIN && state_next == ldr_pkg::ST_IDLE)
            begin
                primed_reg <= 1'b1;
            end
            // Row-major scan position, restarted outside fill and scan
            if (state_reg != ldr_pkg::ST_FILL && state_reg != ldr_pkg::ST_SCAN)
            begin
                idx_reg <= '0;
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (col_reg == ldr_pkg::COL_W'(ldr_pkg::COLS - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (adv)
            begin
                b_vld_reg <= (state_reg == ldr_pkg::ST_SCAN);
            end
            if (adv && take_b)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (flush)
            begin
                pend_vld_reg <= 1'b0;
            end
            if (mid_push || flush)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!led_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers and memories
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (t_we)
        begin
            tmem[t_addr] <= t_wdata;
        end
        if (adv && take_b)
        begin
            smem[b_idx_reg] <= t_eff;
            pend_row_reg    <= b_row_reg;
            pend_col_reg    <= b_col_reg;
            pend_pix_reg    <= t_eff;
        end
        if (adv)
        begin
            t_rd_reg  <= tmem[idx_reg];
            s_rd_reg  <= smem[idx_reg];
            tv_rd_reg <= tvalid_reg[idx_reg];
            b_idx_reg <= idx_reg;
            b_row_reg <= row_reg + ldr_pkg::ROW_W'(1);
            b_col_reg <= col_reg + ldr_pkg::COL_W'(1);
        end
        if (mid_push || flush)
        begin
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_pix_reg  <= pend_pix_reg;
            out_last_reg <= flush;
        end
    end

    assign led_valid = out_vld_reg;
    assign led_row   = out_row_reg;
    assign led_col   = out_col_reg;
    assign red       = out_pix_reg.red;
    assign green     = out_pix_reg.green;
    assign blue      = out_pix_reg.blue;
    assign last      = out_last_reg;

endmodule

// ===== hw/rtl/led_matrix_delta_refresh.sv =====
// Top level of the LED matrix delta refresh block.
// Depends on ldr_pkg, ldr_front, ldr_cmd_fifo and ldr_back.
//
// Usage: commands arrive on the cmd channel (cmd_valid, cmd_stall) and LED
// writes leave on the led channel (led_valid, led_stall); an item moves at a
// rising edge with valid high and stall low. A move clears one pixel, paints
// another and refreshes; a digit command repaints the 7x7 frame from the
// glyph font and gives no writes; a refresh compares target and shadow.
// A two-entry queue lets commands be taken while the back end is busy.
// A refresh walks all 49 pixels, one memory read per cycle unless the scan
// is paused by a stalled receiver, and emits one write per changed pixel
// with 1-based coordinates; last marks the final one.
// The first write of a refresh leaves once the next changed pixel is found,
// or at the end of the scan, as each write is held back one step to learn
// whether it is the last.
// Reset clears the target frame to black; the first refresh then writes
// every pixel. A stalled receiver holds the output register and the scan
// pauses once a further write would be needed.
module led_matrix_delta_refresh (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [ldr_pkg::KIND_W-1:0]      kind,
    input  logic [ldr_pkg::ROW_W-1:0]       from_row,
    input  logic [ldr_pkg::COL_W-1:0]       from_col,
    input  logic [ldr_pkg::ROW_W-1:0]       to_row,
    input  logic [ldr_pkg::COL_W-1:0]       to_col,
    input  logic [ldr_pkg::DIGIT_W-1:0]     digit,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_red,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_green,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  fg_blue,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_red,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_green,
    input  logic [ldr_pkg::COLOR_BITS-1:0]  bg_blue,
    output logic                            led_valid,
    input  logic                            led_stall,
    output logic [ldr_pkg::ROW_W-1:0]       led_row,
    output logic [ldr_pkg::COL_W-1:0]       led_col,
    output logic [ldr_pkg::COLOR_BITS-1:0]  red,
    output logic [ldr_pkg::COLOR_BITS-1:0]  green,
    output logic [ldr_pkg::COLOR_BITS-1:0]  blue,
    output logic                            last
);

    logic          q_full;
    logic          q_push;
    ldr_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          q_not_empty;
    ldr_pkg::cmd_t q_head;

    // Command classification
    ldr_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .kind      (kind),
        .from_row  (from_row),
        .from_col  (from_col),
        .to_row    (to_row),
        .to_col    (to_col),
        .digit     (digit),
        .fg_red    (fg_red),
        .fg_green  (fg_green),
        .fg_blue   (fg_blue),
        .bg_red    (bg_red),
        .bg_green  (bg_green),
        .bg_blue   (bg_blue),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Command queue
    ldr_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Frame update and refresh scan
    ldr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .led_valid   (led_valid),
        .led_stall   (led_stall),
        .led_row     (led_row),
        .led_col     (led_col),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last        (last)
    );

endmodule
